// ===== sv/gh_pkg.sv =====
// Shared types, constants and helpers for the geohash encoder.
package gh_pkg;

    localparam int MAX_PRECISION = 20;
    localparam int PREC_W        = 5;
    localparam int FRAC_W        = 52;
    localparam int CODE_BITS     = 2 * FRAC_W;

    // 360 and 180 degrees scaled by 2^52, 90 degrees scaled by 2^52
    localparam logic [61:0] LON_MOD  = 62'd360 << FRAC_W;
    localparam logic [61:0] LON_HALF = 62'd180 << FRAC_W;
    localparam logic [59:0] LAT_LIM  = 60'd90 << FRAC_W;

    localparam logic [8:0] LON_DIV = 9'd360;
    localparam logic [8:0] LAT_DIV = 9'd180;

    localparam logic [8*32-1:0] GH_ALPHABET = "0123456789bcdefghjkmnpqrstuvwxyz";

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NOT_FINITE = 2'd1,
        ST_BAD_LAT    = 2'd2
    } t_status;

    // Handoff from the converter to the character emitter
    typedef struct packed {
        logic                load;
        t_status             status;
        logic [PREC_W-1:0]   prec;
        logic [FRAC_W-1:0]   lat_frac;
        logic [FRAC_W-1:0]   lon_frac;
    } t_emit_req;

    function automatic logic [7:0] gh_char(input logic [4:0] code);
        gh_char = GH_ALPHABET[8*(31-int'(code)) +: 8];
    endfunction

endpackage

// ===== sv/gh_if.sv =====
// Handshake channel interfaces for points in and hash characters out.
interface gh_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] latitude_bits;
    logic [63:0] longitude_bits;
    modport source(output valid, latitude_bits, longitude_bits, input ready);
    modport sink(input valid, latitude_bits, longitude_bits, output ready);
endinterface

interface gh_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] hash_char;
    logic [1:0] status;
    logic       last;
    modport source(output valid, hash_char, status, last, input ready);
    modport sink(input valid, hash_char, status, last, output ready);
endinterface

// ===== sv/gh_div.sv =====
// Bit-serial restoring divider: 52 quotient bits, one per cycle.
module gh_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [60:0]               i_dividend,
    input  logic [8:0]                i_divisor,
    output logic                      o_done,
    output logic [gh_pkg::FRAC_W-1:0] o_quot
);

    logic [60:0]               r_rem;
    logic [59:0]               r_den;
    logic [gh_pkg::FRAC_W-1:0] r_quot;
    logic [5:0]                r_cnt;
    logic                      r_busy;
    logic                      r_done;
    logic                      n_ge;

    assign n_ge   = r_rem >= {1'b0, r_den};
    assign o_done = r_done;
    assign o_quot = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= i_dividend;
                r_den  <= {i_divisor, 51'd0};
                r_cnt  <= 6'(gh_pkg::FRAC_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (n_ge) begin
                    r_rem <= r_rem - {1'b0, r_den};
                end
                r_quot <= {r_quot[gh_pkg::FRAC_W-2:0], n_ge};
                r_den  <= r_den >> 1;
                r_cnt  <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== sv/gh_emit.sv =====
// Character emitter: interleaves the fractions and sends one base32 char per transaction.
module gh_emit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gh_pkg::t_emit_req i_req,
    output logic              o_load_ready,
    gh_out_if.source          o_out
);

    logic [gh_pkg::CODE_BITS-1:0] n_bits;
    logic [gh_pkg::CODE_BITS-1:0] r_bits;
    logic [gh_pkg::PREC_W-1:0]    r_left;
    logic                         r_valid;
    logic [7:0]                   r_char;
    gh_pkg::t_status              r_status;
    logic                         r_last;

    // longitude bit first, then latitude, MSB first
    always_comb begin
        for (int i = 0; i < gh_pkg::FRAC_W; i++) begin
            n_bits[2*i+1] = i_req.lon_frac[i];
            n_bits[2*i]   = i_req.lat_frac[i];
        end
    end

    assign o_load_ready    = !r_valid;
    assign o_out.valid     = r_valid;
    assign o_out.hash_char = r_char;
    assign o_out.status    = r_status;
    assign o_out.last      = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_req.load) begin
            r_valid <= 1'b1;
            if (i_req.status != gh_pkg::ST_OK) begin
                r_char   <= 8'd0;
                r_status <= i_req.status;
                r_last   <= 1'b1;
                r_left   <= '0;
            end else begin
                r_char   <= gh_pkg::gh_char(n_bits[gh_pkg::CODE_BITS-1 -: 5]);
                r_status <= gh_pkg::ST_OK;
                r_bits   <= {n_bits[gh_pkg::CODE_BITS-6:0], 5'd0};
                r_left   <= i_req.prec - 5'd1;
                r_last   <= i_req.prec == 5'd1;
            end
        end else if (r_valid && o_out.ready) begin
            if (r_left != '0) begin
                r_char <= gh_pkg::gh_char(r_bits[gh_pkg::CODE_BITS-1 -: 5]);
                r_bits <= {r_bits[gh_pkg::CODE_BITS-6:0], 5'd0};
                r_left <= r_left - 5'd1;
                r_last <= r_left == 5'd1;
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== sv/geohash_encoder_core.sv =====
// Geohash encoder top level: double decode, serial reduction, division and emission.
//
//  channel | dir | payload                              | accepted when
//  i_in    | in  | latitude_bits, longitude_bits        | valid && ready
//  o_out   | out | hash_char, status, last              | valid && ready
//  i_cfg   | in  | precision (5 bits)                   | i_cfg_we high
//
// Per point: accept, then the shift loop (longitude mod-360 doubling, exponent folded by
// the period-12 order of 2 mod 45, or a right shift capped at 53, plus the exit check),
// the fixup states (round, negate, wrap, divider start), the dividers (52 quotient bits of
// both fractions in parallel, plus the done check) and the handoff, then one character per
// cycle while the output is ready.
// Not-finite points and latitudes of magnitude 128 or more skip to the handoff after
// the decode; other out-of-range latitudes leave at the negate step.
// Reset is synchronous, active low; precision resets to 9.
// The emitter holds its own copy of the result, so a new point is accepted while
// characters of the previous one still wait on a stalled output.
module geohash_encoder_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [gh_pkg::PREC_W-1:0] i_cfg_data,
    gh_in_if.sink                     i_in,
    gh_out_if.source                  o_out
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_ROUND,
        S_NEGATE,
        S_WRAP,
        S_DSTART,
        S_DIV,
        S_HAND
    } t_state;

    t_state                    r_state;
    logic [gh_pkg::PREC_W-1:0] r_precision;
    gh_pkg::t_status           r_status;

    // longitude datapath: residue mod 360*2^52 or right-shifted mantissa
    logic [61:0] r_lon_r;
    logic [6:0]  r_lon_cnt;
    logic        r_lon_left;
    logic        r_lon_stk;
    logic        r_lon_neg;

    // latitude datapath: magnitude, then offset value
    logic [59:0] r_lat_m;
    logic [6:0]  r_lat_cnt;
    logic        r_lat_left;
    logic        r_lat_stk;
    logic        r_lat_neg;

    // decode of the incoming transaction
    logic [10:0] n_lon_exp, n_lat_exp;
    logic [52:0] n_lon_mant, n_lat_mant;
    logic [10:0] n_lon_sh, n_lon_x;
    logic [22:0] n_lon_prod;
    logic [10:0] n_lon_rem;
    logic [6:0]  n_lon_cnt, n_lat_cnt;
    logic [10:0] n_lon_s, n_lat_s;
    logic        n_not_finite, n_lat_big;
    logic [61:0] n_lon_dbl;
    logic        n_lat_bad;
    logic [gh_pkg::PREC_W-1:0] n_prec;

    logic                      w_start;
    logic                      w_lat_done, w_lon_done;
    logic [gh_pkg::FRAC_W-1:0] w_lat_frac, w_lon_frac;
    logic                      w_load_ready;
    gh_pkg::t_emit_req         w_req;

    always_comb begin
        n_lon_exp  = i_in.longitude_bits[62:52];
        n_lat_exp  = i_in.latitude_bits[62:52];
        n_lon_mant = {n_lon_exp != 11'd0, i_in.longitude_bits[51:0]};
        n_lat_mant = {n_lat_exp != 11'd0, i_in.latitude_bits[51:0]};
        n_not_finite = (n_lon_exp == 11'h7FF) || (n_lat_exp == 11'h7FF);
        n_lat_big    = n_lat_exp >= 11'd1030;

        // left shifts past 66 fold by 12: 2^12 = 1 mod 45 and 360*2^52 = 45*2^55
        n_lon_sh   = n_lon_exp - 11'd1023;
        n_lon_x    = n_lon_sh - 11'd55;
        n_lon_prod = 23'(n_lon_x) * 23'd2731;
        n_lon_rem  = n_lon_x - 11'(11'd12 * 11'(n_lon_prod[22:15]));
        n_lon_s    = (n_lon_exp == 11'd0) ? 11'd1022 : 11'd1023 - n_lon_exp;
        n_lat_s    = (n_lat_exp == 11'd0) ? 11'd1022 : 11'd1023 - n_lat_exp;

        if (n_lon_exp >= 11'd1023) begin
            n_lon_cnt = (n_lon_sh >= 11'd67) ? 7'd55 + 7'(n_lon_rem[3:0]) : 7'(n_lon_sh);
        end else begin
            n_lon_cnt = (n_lon_s >= 11'd53) ? 7'd53 : 7'(n_lon_s);
        end
        if (n_lat_exp >= 11'd1023) begin
            n_lat_cnt = 7'(n_lat_exp - 11'd1023);
        end else begin
            n_lat_cnt = (n_lat_s >= 11'd53) ? 7'd53 : 7'(n_lat_s);
        end

        n_lon_dbl = {r_lon_r[60:0], 1'b0};
        n_lat_bad = r_lat_neg ? (r_lat_m > gh_pkg::LAT_LIM) : (r_lat_m >= gh_pkg::LAT_LIM);

        if (r_precision == '0) begin
            n_prec = 5'd1;
        end else if (r_precision > 5'(gh_pkg::MAX_PRECISION)) begin
            n_prec = 5'(gh_pkg::MAX_PRECISION);
        end else begin
            n_prec = r_precision;
        end
    end

    assign i_in.ready = r_state == S_IDLE;
    assign w_start    = r_state == S_DSTART;

    always_comb begin
        w_req.load     = (r_state == S_HAND) && w_load_ready;
        w_req.status   = r_status;
        w_req.prec     = n_prec;
        w_req.lat_frac = w_lat_frac;
        w_req.lon_frac = w_lon_frac;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_precision <= 5'd9;
            r_status    <= gh_pkg::ST_OK;
        end else begin
            if (i_cfg_we) begin
                r_precision <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_lon_neg  <= i_in.longitude_bits[63];
                        r_lat_neg  <= i_in.latitude_bits[63];
                        r_lon_r    <= 62'(n_lon_mant);
                        r_lat_m    <= 60'(n_lat_mant);
                        r_lon_cnt  <= n_lon_cnt;
                        r_lat_cnt  <= n_lat_cnt;
                        r_lon_left <= n_lon_exp >= 11'd1023;
                        r_lat_left <= n_lat_exp >= 11'd1023;
                        r_lon_stk  <= 1'b0;
                        r_lat_stk  <= 1'b0;
                        if (n_not_finite) begin
                            r_status <= gh_pkg::ST_NOT_FINITE;
                            r_state  <= S_HAND;
                        end else if (n_lat_big) begin
                            r_status <= gh_pkg::ST_BAD_LAT;
                            r_state  <= S_HAND;
                        end else begin
                            r_status <= gh_pkg::ST_OK;
                            r_state  <= S_SHIFT;
                        end
                    end
                end
                S_SHIFT: begin
                    if (r_lon_cnt != 7'd0) begin
                        if (r_lon_left) begin
                            r_lon_r <= (n_lon_dbl >= gh_pkg::LON_MOD)
                                       ? n_lon_dbl - gh_pkg::LON_MOD : n_lon_dbl;
                        end else begin
                            r_lon_r   <= r_lon_r >> 1;
                            r_lon_stk <= r_lon_stk | r_lon_r[0];
                        end
                        r_lon_cnt <= r_lon_cnt - 7'd1;
                    end
                    if (r_lat_cnt != 7'd0) begin
                        if (r_lat_left) begin
                            r_lat_m <= {r_lat_m[58:0], 1'b0};
                        end else begin
                            r_lat_m   <= r_lat_m >> 1;
                            r_lat_stk <= r_lat_stk | r_lat_m[0];
                        end
                        r_lat_cnt <= r_lat_cnt - 7'd1;
                    end
                    if (r_lon_cnt == 7'd0 && r_lat_cnt == 7'd0) begin
                        r_state <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    // negative values round away from zero (floor)
                    r_lon_r <= r_lon_r + 62'(r_lon_stk & r_lon_neg);
                    r_lat_m <= r_lat_m + 60'(r_lat_stk & r_lat_neg);
                    r_state <= S_NEGATE;
                end
                S_NEGATE: begin
                    if (r_lon_neg && r_lon_r != '0) begin
                        r_lon_r <= gh_pkg::LON_MOD - r_lon_r;
                    end
                    if (n_lat_bad) begin
                        r_status <= gh_pkg::ST_BAD_LAT;
                        r_state  <= S_HAND;
                    end else begin
                        r_lat_m <= r_lat_neg ? gh_pkg::LAT_LIM - r_lat_m
                                             : gh_pkg::LAT_LIM + r_lat_m;
                        r_state <= S_WRAP;
                    end
                end
                S_WRAP: begin
                    // +180 mod 360
                    r_lon_r <= (r_lon_r >= gh_pkg::LON_HALF) ? r_lon_r - gh_pkg::LON_HALF
                                                             : r_lon_r + gh_pkg::LON_HALF;
                    r_state <= S_DSTART;
                end
                S_DSTART: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_lat_done && w_lon_done) begin
                        r_state <= S_HAND;
                    end
                end
                S_HAND: begin
                    if (w_load_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    gh_div u_div_lon (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (r_lon_r[60:0]),
        .i_divisor  (gh_pkg::LON_DIV),
        .o_done     (w_lon_done),
        .o_quot     (w_lon_frac)
    );

    gh_div u_div_lat (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend ({1'b0, r_lat_m}),
        .i_divisor  (gh_pkg::LAT_DIV),
        .o_done     (w_lat_done),
        .o_quot     (w_lat_frac)
    );

    gh_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (w_req),
        .o_load_ready (w_load_ready),
        .o_out        (o_out)
    );

`ifndef SYNTHESIS
    a_ok_char_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status == gh_pkg::ST_OK) |-> (o_out.hash_char != 8'd0))
        else $error("ok transaction carries a zero character");

    a_error_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status != gh_pkg::ST_OK) |-> (o_out.last && o_out.hash_char == 8'd0))
        else $error("error transaction not marked last or carries a character");

    a_one_point_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input taken while a point is in flight");

    a_dividers_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_lat_done == w_lon_done)
        else $error("latitude and longitude dividers out of step");
`endif

endmodule
